>>> design/residual_stream_mix_bf16_core_macros.svh
// assertion macros shared by the residual stream mix design
`ifndef RESIDUAL_STREAM_MIX_BF16_CORE_MACROS_SVH
`define RESIDUAL_STREAM_MIX_BF16_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RSM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsm assertion failed");
`define RSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsm assertion failed");
`else
`define RSM_ASSERT_SAME(lbl, ante, cons)
`define RSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/rsm_pkg.sv
// types, constants and fp32 datapath functions for the residual stream mix
package rsm_pkg;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16 = 16'h7FC0;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MIX  = 1'b1;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sign;
    logic [47:0] prod;
    logic [9:0]  esum;
  } mul_s1_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [10:0] expo;
    logic [47:0]        sig;
  } norm_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sign;
    logic        zsign;
    logic        sub;
    logic [7:0]  expo;
    logic [27:0] opa;
    logic [27:0] opb;
  } add_s1_t;

  function automatic logic is_nan(logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic [5:0] lead48(logic [47:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [4:0] lead28(logic [27:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // unpack, special cases and mantissa product
  function automatic mul_s1_t fmul_s1(logic [31:0] a, logic [31:0] b);
    mul_s1_t    r;
    logic       az;
    logic       bz;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [23:0] ma;
    logic [23:0] mb;
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    r.sign = a[31] ^ b[31];
    r.spec = is_nan(a) | is_nan(b) | is_inf(a) | is_inf(b) | az | bz;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (is_inf(b) && az)) begin
      r.spec_bits = QNAN32;
    end else if (is_inf(a) || is_inf(b)) begin
      r.spec_bits = {r.sign, 8'hFF, 23'd0};
    end else begin
      r.spec_bits = {r.sign, 31'd0};
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    r.prod = ma * mb;
    r.esum = {2'd0, ea} + {2'd0, eb};
    return r;
  endfunction

  // bring the leading one of the product to the top bit
  function automatic norm_t fmul_s2(mul_s1_t m);
    norm_t      n;
    logic [5:0] l;
    l = lead48(m.prod);
    n.spec = m.spec;
    n.spec_bits = m.spec_bits;
    n.sign = m.sign;
    n.sig = m.prod << (6'd47 - l);
    n.expo = $signed({1'b0, m.esum}) + $signed({5'd0, l}) - 11'sd173;
    return n;
  endfunction

  // gradual underflow, round to nearest even and pack
  function automatic logic [31:0] fround(norm_t n);
    logic [95:0] sh;
    logic [5:0]  amt;
    logic [10:0] base;
    logic [34:0] wide;
    logic [23:0] m;
    logic        g;
    logic        st;
    logic        rnd;
    logic [31:0] res;
    if (n.expo < 11'sd1) begin
      amt  = (n.expo < -11'sd48) ? 6'd49 : 6'(11'sd1 - n.expo);
      base = 11'd0;
    end else begin
      amt  = 6'd0;
      base = 11'(n.expo - 11'sd1);
    end
    sh   = {n.sig, 48'd0} >> amt;
    m    = sh[95:72];
    g    = sh[71];
    st   = |sh[70:0];
    rnd  = g & (st | m[0]);
    wide = {1'b0, base, 23'd0} + 35'(m) + 35'(rnd);
    if (wide[34:23] >= 12'd255) begin
      res = {n.sign, 8'hFF, 23'd0};
    end else begin
      res = {n.sign, wide[30:0]};
    end
    return n.spec ? n.spec_bits : res;
  endfunction

  // order by magnitude and align the smaller operand with sticky
  function automatic add_s1_t fadd_s1(logic [31:0] a, logic [31:0] b);
    add_s1_t     r;
    logic        swp;
    logic [31:0] big;
    logic [31:0] lit;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [5:0]  amt;
    logic [53:0] al;
    logic [26:0] up;
    swp = (b[30:0] > a[30:0]);
    big = swp ? b : a;
    lit = swp ? a : b;
    r.spec = is_nan(a) | is_nan(b) | is_inf(a) | is_inf(b);
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
      r.spec_bits = QNAN32;
    end else if (is_inf(a)) begin
      r.spec_bits = a;
    end else begin
      r.spec_bits = b;
    end
    eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
    d   = eb - es;
    amt = (d > 8'd30) ? 6'd30 : d[5:0];
    al  = {lit[30:23] != 8'd0, lit[22:0], 3'd0, 27'd0} >> amt;
    up  = al[53:27] | {26'd0, |al[26:0]};
    r.sign  = big[31];
    r.zsign = a[31] & b[31];
    r.sub   = a[31] ^ b[31];
    r.expo  = eb;
    r.opa   = {1'b0, big[30:23] != 8'd0, big[22:0], 3'd0};
    r.opb   = {1'b0, up};
    return r;
  endfunction

  // carry a finished word through the adder untouched
  function automatic add_s1_t fadd_pass(logic [31:0] f);
    add_s1_t r;
    r = '0;
    r.spec = 1'b1;
    r.spec_bits = f;
    return r;
  endfunction

  function automatic norm_t fadd_s2(add_s1_t r);
    norm_t       n;
    logic [27:0] s;
    logic [4:0]  l;
    s = r.sub ? (r.opa - r.opb) : (r.opa + r.opb);
    l = lead28(s);
    n.sign = r.sign;
    n.sig  = {s, 20'd0} << (5'd27 - l);
    n.expo = $signed({3'd0, r.expo}) + $signed({6'd0, l}) - 11'sd26;
    if (r.spec) begin
      n.spec = 1'b1;
      n.spec_bits = r.spec_bits;
    end else if (s == 28'd0) begin
      // exact cancellation or two zeros
      n.spec = 1'b1;
      n.spec_bits = {r.zsign, 31'd0};
    end else begin
      n.spec = 1'b0;
      n.spec_bits = 32'd0;
    end
    return n;
  endfunction

  function automatic logic [15:0] bf16_rne(logic [31:0] f);
    logic [31:0] t;
    t = f + 32'h0000_7FFF + {31'd0, f[16]};
    return is_nan(f) ? QNAN16 : t[31:16];
  endfunction

endpackage

>>> design/residual_stream_mix_bf16_core.sv
// residual stream mix top level: weight store, cell chain and output register
//
//  channel   dir  tdata (low bit first)                          tuser
//  s_axis    in   weight_index, weight_bits, projected_value,    command
//                 residual_0..residual_N-1, zero fill
//  m_axis    out  mixed_0..mixed_N-1                             -
//
// a mix transaction is taken every cycle unless m_axis back-pressure stalls the cells;
// it passes through the six stage multiply and add in each of the NUM_STREAMS+1 cells
// (one per residual stream, one for the gain) and then through the output register.
// a weight load waits until no mix transaction is in the cells, then is written on its handshake.
// reset clears the valid bits only; the weight store is undefined until written.
// m_axis back-pressure stalls only the stages that are full.
`include "residual_stream_mix_bf16_core_macros.svh"
module residual_stream_mix_bf16_core import rsm_pkg::*; #(
  parameter int NUM_STREAMS = 4,
  localparam int DEPTH = NUM_STREAMS * NUM_STREAMS + NUM_STREAMS,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int IN_W = IDX_W + 48 + 16 * NUM_STREAMS,
  localparam int S_W = ((IN_W + 7) / 8) * 8,
  localparam int M_W = 16 * NUM_STREAMS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // weight_index, weight_bits, projected_value, residual_0.., zero fill
  input  logic [S_W-1:0] s_axis_tdata,
  // command
  input  logic           s_axis_tuser,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // mixed_0, mixed_1, ..
  output logic [M_W-1:0] m_axis_tdata
);

  localparam int NS = NUM_STREAMS;

  logic [DEPTH-1:0][31:0]            store_q;
  logic [IDX_W-1:0]                  widx;
  logic [NS+1:0]                     cell_v;
  logic [NS+1:0]                     cell_rdy;
  logic [NS+1:0][NS:0][15:0]         cell_ops;
  logic [NS+1:0][NS-1:0][31:0]       cell_acc;
  logic [NS:0][NS-1:0][31:0]         cell_wgt;
  logic [NS:0]                       cell_busy;
  logic                              busy;
  logic                              out_v_q;
  logic [NS-1:0][15:0]               out_data_q;
  logic                              load_acc;

  assign widx = s_axis_tdata[IDX_W-1:0];
  assign busy = |cell_busy;

  assign s_axis_tready = (s_axis_tuser == CMD_MIX) ? cell_rdy[0] : !busy;
  assign load_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD);

  always_ff @(posedge clk_i) begin
    if (load_acc && ({1'b0, widx} < (IDX_W + 1)'(DEPTH))) begin
      store_q[widx] <= s_axis_tdata[IDX_W +: 32];
    end
  end

  // stream values sit at 0..NS-1, the projected value at NS
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      cell_ops[0][s] = s_axis_tdata[IDX_W + 48 + 16 * s +: 16];
    end
    cell_ops[0][NS] = s_axis_tdata[IDX_W + 32 +: 16];
  end
  assign cell_v[0]   = s_axis_tvalid && (s_axis_tuser == CMD_MIX);
  assign cell_acc[0] = '0;

  for (genvar c = 0; c <= NS; c++) begin : g_cell
    for (genvar t = 0; t < NS; t++) begin : g_wgt
      if (c < NS) begin : g_mix
        assign cell_wgt[c][t] = store_q[t * NS + c];
      end else begin : g_gain
        assign cell_wgt[c][t] = store_q[NS * NS + t];
      end
    end

    rsm_cell #(
      .NS  (NS),
      .IDX (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_v[c]),
      .ready_o (cell_rdy[c]),
      .ops_i   (cell_ops[c]),
      .acc_i   (cell_acc[c]),
      .wgt_i   (cell_wgt[c]),
      .valid_o (cell_v[c+1]),
      .ready_i (cell_rdy[c+1]),
      .ops_o   (cell_ops[c+1]),
      .acc_o   (cell_acc[c+1]),
      .busy_o  (cell_busy[c])
    );
  end

  assign cell_rdy[NS+1] = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cell_rdy[NS+1]) begin
      out_v_q <= cell_v[NS+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_rdy[NS+1] && cell_v[NS+1]) begin
      for (int t = 0; t < NS; t++) out_data_q[t] <= bf16_rne(cell_acc[NS+1][t]);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  `RSM_ASSERT_SAME(a_load_when_drained, load_acc, !busy)
  `RSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `RSM_ASSERT_NEXT(a_out_drain, m_axis_tvalid && m_axis_tready && !cell_v[NS+1],
                   !m_axis_tvalid)

endmodule

>>> design/rsm_cell.sv
// one cell of the mix chain: per-target multiply by a weight and accumulate
`include "residual_stream_mix_bf16_core_macros.svh"
module rsm_cell import rsm_pkg::*; #(
  parameter int NS  = 4,
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [NS:0][15:0]         ops_i,
  input  logic [NS-1:0][31:0]       acc_i,
  input  logic [NS-1:0][31:0]       wgt_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [NS:0][15:0]         ops_o,
  output logic [NS-1:0][31:0]       acc_o,
  output logic                      busy_o
);

  logic [5:0]                 v_q;
  logic [6:0]                 en;
  logic [5:0][NS:0][15:0]     ops_q;
  logic [2:0][NS-1:0][31:0]   acc_q;
  mul_s1_t [NS-1:0]           s1_q;
  norm_t   [NS-1:0]           s2_q;
  logic [NS-1:0][31:0]        s3_q;
  add_s1_t [NS-1:0]           s4_q;
  norm_t   [NS-1:0]           s5_q;
  logic [NS-1:0][31:0]        s6_q;
  add_s1_t [NS-1:0]           s4_d;
  logic [31:0]                op32;

  assign op32 = {ops_i[IDX], 16'd0};

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[6] = ready_i;
    for (int k = 5; k >= 0; k--) begin
      en[k] = !v_q[k] | en[k+1];
    end
  end

  // first cell has nothing to accumulate onto
  always_comb begin
    for (int t = 0; t < NS; t++) begin
      s4_d[t] = (IDX == 0) ? fadd_pass(s3_q[t]) : fadd_s1(acc_q[2][t], s3_q[t]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ops_q[0] <= ops_i;
      acc_q[0] <= acc_i;
      for (int t = 0; t < NS; t++) s1_q[t] <= fmul_s1(op32, wgt_i[t]);
    end
    if (en[1]) begin
      ops_q[1] <= ops_q[0];
      acc_q[1] <= acc_q[0];
      for (int t = 0; t < NS; t++) s2_q[t] <= fmul_s2(s1_q[t]);
    end
    if (en[2]) begin
      ops_q[2] <= ops_q[1];
      acc_q[2] <= acc_q[1];
      for (int t = 0; t < NS; t++) s3_q[t] <= fround(s2_q[t]);
    end
    if (en[3]) begin
      ops_q[3] <= ops_q[2];
      s4_q     <= s4_d;
    end
    if (en[4]) begin
      ops_q[4] <= ops_q[3];
      for (int t = 0; t < NS; t++) s5_q[t] <= fadd_s2(s4_q[t]);
    end
    if (en[5]) begin
      ops_q[5] <= ops_q[4];
      for (int t = 0; t < NS; t++) s6_q[t] <= fround(s5_q[t]);
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[5];
  assign ops_o   = ops_q[5];
  assign acc_o   = s6_q;
  assign busy_o  = |v_q;

  `RSM_ASSERT_NEXT(a_cell_out_hold, valid_o && !ready_i, valid_o && $stable(acc_o))
  `RSM_ASSERT_NEXT(a_cell_stage_move, v_q[2] && en[3], v_q[3])
  `RSM_ASSERT_NEXT(a_cell_no_spawn, !valid_i && !busy_o, !busy_o)

endmodule

>>> bench/testbench.sv
// self-checking bench for the bf16 residual stream mix core
module testbench;
  import rsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = 4;
  localparam int DEPTH = NS * NS + NS;
  localparam int GAIN_BASE = NS * NS;
  localparam int S_W = 120;
  localparam int M_W = 16 * NS;
  localparam int CYCLE_LIMIT = 1000000;

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata;
  logic           s_axis_tuser;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [M_W-1:0] m_axis_tdata;

  residual_stream_mix_bf16_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [31:0]    weight_copy[DEPTH];
  logic [M_W-1:0] pending_mix[$];
  int             error_count;
  int             cycle_count;
  int             rx_hold_left;
  bit             tx_idle_on;
  bit             rx_idle_on;
  bit             long_hold_req;
  bit             long_hold_done;

  initial begin
    clk_i = 1'b0;
    cycle_count = 0;
    forever begin
      #10 clk_i = 1'b1;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("residual_stream_mix_bf16_core test failed");
        $finish;
      end
      #10 clk_i = 1'b0;
    end
  end

  // fp32 bit pattern to an exact double
  function automatic real fp32_to_real(logic [31:0] f);
    logic [63:0] d;
    int          p;
    d = {f[31], 63'd0};
    if (f[30:23] == 8'hFF) begin
      d[62:0] = {11'h7FF, f[22:0], 29'd0};
    end else if (f[30:23] != 8'd0) begin
      d[62:0] = {11'(f[30:23] + 11'd896), f[22:0], 29'd0};
    end else if (f[22:0] != 23'd0) begin
      p = 0;
      for (int i = 0; i < 23; i++) if (f[i]) p = i;
      d[62:52] = 11'(p + 874);
      d[51:0] = 52'(64'(f[22:0]) << (52 - p));
    end
    return $bitstoreal(d);
  endfunction

  // round a double to fp32, nearest even, with gradual underflow
  function automatic logic [31:0] real_to_fp32(real v);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] val;
    logic        up;
    int          ex;
    int          sh;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 52'd0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    ex = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    up = (rem > half) || ((rem == half) && kept[0]);
    val = (ex >= -126) ? (64'(ex + 126) << 23) + kept + 64'(up) : kept + 64'(up);
    if (val >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
    return {d[63], val[30:0]};
  endfunction

  function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
    return real_to_fp32(fp32_to_real(a) * fp32_to_real(b));
  endfunction

  function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
    return real_to_fp32(fp32_to_real(a) + fp32_to_real(b));
  endfunction

  function automatic logic [15:0] to_bf16(logic [31:0] f);
    logic [31:0] t;
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) return QNAN16;
    t = f + 32'h0000_7FFF + {31'd0, f[16]};
    return t[31:16];
  endfunction

  // apply one accepted transaction to the weight copy or forecast its mix
  task automatic model_transaction(logic cmd, logic [S_W-1:0] data);
    logic [4:0]     idx;
    logic [31:0]    acc;
    logic [31:0]    xf;
    logic [M_W-1:0] mixed;
    idx = data[4:0];
    if (cmd == CMD_LOAD) begin
      if (idx < DEPTH) weight_copy[idx] = data[36:5];
    end else begin
      xf = {data[52:37], 16'd0};
      for (int t = 0; t < NS; t++) begin
        acc = fp32_mul({data[53 +: 16], 16'd0}, weight_copy[t * NS]);
        for (int s = 1; s < NS; s++)
          acc = fp32_add(acc, fp32_mul({data[53 + 16 * s +: 16], 16'd0},
                                       weight_copy[t * NS + s]));
        mixed[16 * t +: 16] = to_bf16(fp32_add(fp32_mul(xf, weight_copy[GAIN_BASE + t]), acc));
      end
      pending_mix.push_back(mixed);
    end
  endtask

  task automatic report_mismatch(string what, int field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s field %0d: got %h expected %h at cycle %0d",
             what, field, got, want, cycle_count);
    error_count++;
  endtask

  // sends one transaction and waits for the handshake
  task automatic send_item(logic cmd, logic [4:0] idx, logic [31:0] wbits,
                           logic [15:0] x, logic [63:0] res);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'd0, res, x, wbits, idx};
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) break;
    end
    model_transaction(s_axis_tuser, s_axis_tdata);
  endtask

  task automatic send_load(int idx, logic [31:0] wbits);
    send_item(CMD_LOAD, 5'(idx), wbits, 16'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_mix(logic [15:0] x, logic [63:0] res);
    send_item(CMD_MIX, 5'($urandom), $urandom, x, res);
  endtask

  function automatic logic [31:0] pick_weight();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return {1'($urandom), 8'($urandom_range(118, 132)), 23'($urandom)};
    if (k < 85) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom), 8'h00, 23'($urandom)};
      3: return {1'($urandom), 8'hFE, 23'($urandom)};
      4: return {1'($urandom), 8'hFF, 23'd0};
      default: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
    endcase
  endfunction

  function automatic logic [15:0] pick_bf16();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return {1'($urandom), 8'($urandom_range(115, 135)), 7'($urandom)};
    return 16'($urandom);
  endfunction

  function automatic logic [63:0] pick_residuals();
    return {pick_bf16(), pick_bf16(), pick_bf16(), pick_bf16()};
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiving side: random stalls, optional long hold, compares results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_mix.size() == 0) begin
          $display("unexpected result %h at cycle %0d", m_axis_tdata, cycle_count);
          error_count++;
        end else begin
          for (int t = 0; t < NS; t++)
            if (m_axis_tdata[16 * t +: 16] !== pending_mix[0][16 * t +: 16])
              report_mismatch("mixed", t, m_axis_tdata[16 * t +: 16],
                              pending_mix[0][16 * t +: 16]);
          void'(pending_mix.pop_front());
        end
        rx_hold_left = rx_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (long_hold_req && !long_hold_done) begin
        rx_hold_left = 300;
        long_hold_done = 1'b1;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // whole store first so no compute ever reads an unwritten entry
  task automatic test_weight_load();
    for (int i = 0; i < DEPTH; i++)
      send_load(i, (i >= GAIN_BASE || i % (NS + 1) == 0) ? 32'h3F80_0000 : 32'h3E00_0000);
    // out of range indexes must leave the store alone
    send_load(20, 32'hFFFF_FFFF);
    send_load(31, 32'h7F80_0000);
  endtask

  task automatic test_directed_mix();
    send_mix(16'h0000, 64'h0);
    send_mix(16'h8000, 64'h8000_8000_8000_8000);
    send_mix(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_mix(16'h7F80, 64'hFF80_0000_0000_0000);
    send_mix(16'h7F7F, 64'h7F7F_7F7F_7F7F_7F7F);
    send_mix(16'h0001, 64'h8001_0001_807F_007F);
    send_mix(16'h3F80, 64'h4000_C000_3F80_BF80);
    send_mix(16'h7FC1, 64'h3F80_3F80_3F80_3F80);
    // gain a hair above one pushes max bf16 past the range
    send_load(GAIN_BASE, 32'h3F80_FFFF);
    send_mix(16'h7F7F, 64'h0);
    // infinite, subnormal and largest negative finite weights
    send_load(0, 32'h7F80_0000);
    send_load(1, 32'h0000_0001);
    send_load(6, 32'hFF7F_FFFF);
    send_mix(16'h0000, 64'h0000_0000_0000_0000);
    send_mix(16'h3F80, 64'h0000_0000_4000_3F80);
    send_mix(16'hBF80, 64'h0000_4080_0000_3F80);
    wait_drained();
  endtask

  task automatic test_random_mix(int count);
    int n;
    n = 0;
    while (n < count) begin
      if (n % 100 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) send_load($urandom_range(0, 31), pick_weight());
      end else begin
        send_mix(pick_bf16(), pick_residuals());
      end
      n++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    @(posedge clk_i);
    long_hold_req = 1'b1;
    repeat (80) send_mix(pick_bf16(), pick_residuals());
    // loads behind a full pipeline
    repeat (4) send_load($urandom_range(0, DEPTH - 1), pick_weight());
    repeat (20) send_mix(pick_bf16(), pick_residuals());
    tx_idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD;
    error_count = 0;
    long_hold_req = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_weight_load();
    test_directed_mix();
    for (int i = 0; i < DEPTH; i++) send_load(i, pick_weight());
    test_random_mix(1050);
    test_output_stall();
    wait_drained();
    if (error_count == 0 && pending_mix.size() == 0) begin
      $display("residual_stream_mix_bf16_core test passed");
    end else begin
      $display("residual_stream_mix_bf16_core test failed");
    end
    $finish;
  end

endmodule
